[sv/crossfading_input_selector_unit_assert.svh]
// Assertion macros for the crossfading input selector.
`ifndef CROSSFADING_INPUT_SELECTOR_UNIT_ASSERT_SVH
`define CROSSFADING_INPUT_SELECTOR_UNIT_ASSERT_SVH

// Checked while the block is out of reset.
`define CFIS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cfis_pkg.sv]
// ----------------------------------------------------------------------------
// cfis_pkg
// Shared constants, types and tables of the crossfading input selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfis_pkg;

    localparam int MAX_INPUTS  = 8;
    localparam int LANE_BITS   = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int CNT_BITS    = 16;
    localparam int GAIN_BITS   = 16;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + LANE_BITS + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE    = 16'd32768;
    localparam logic [14:0]          GAIN_EP_MAX = 15'd32735;

    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [30:0] SIN_B = 31'd693598668;
    localparam logic [30:0] SIN_C = 31'd85569306;
    localparam logic [30:0] SIN_D = 31'd5026995;
    localparam logic [30:0] SIN_E = 31'd172271;

    localparam logic [1:0] REG_INPUT_COUNT = 2'd0;
    localparam logic [1:0] REG_FADE_TICKS  = 2'd1;
    localparam logic [1:0] REG_FADE_SHAPE  = 2'd2;

    typedef struct packed {
        logic                start;
        logic                enabled;
        logic                active;
        logic [CNT_BITS-1:0] ticks;
        logic                shape;
    } t_lane_ctl;

    typedef struct packed {
        logic                        done;
        logic signed [PROD_BITS-1:0] product;
    } t_lane_stat;

    // Coefficient subtracted at each Horner step of the sine polynomial.
    function automatic logic [30:0] poly_coef(input logic [2:0] step);
        logic [30:0] c;
        unique case (step)
            3'd1:    c = SIN_D;
            3'd2:    c = SIN_C;
            3'd3:    c = SIN_B;
            3'd4:    c = SIN_A;
            default: c = SIN_E;
        endcase
        return c;
    endfunction

endpackage

[sv/cfis_lane.sv]
// ----------------------------------------------------------------------------
// cfis_lane
// One input lane: fade counter, gain by long division, optional sine shaping
// and the weighted sample product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfis_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cfis_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample,
    output cfis_pkg::t_lane_stat                  o_stat
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_DIV  = 4'b0010,
        L_POLY = 4'b0100,
        L_MUL  = 4'b1000
    } t_lstate;

    t_lstate r_state, n_state;
    logic                                r_done, n_done;
    logic [cfis_pkg::CNT_BITS-1:0]       r_count, n_count;
    logic [cfis_pkg::GAIN_BITS-1:0]      r_gain, n_gain;
    logic [cfis_pkg::GAIN_BITS-1:0]      r_mix_gain, n_mix_gain;
    logic [cfis_pkg::CNT_BITS:0]         r_rem, n_rem;
    logic [14:0]                         r_quo, n_quo;
    logic [3:0]                          r_step, n_step;
    logic [29:0]                         r_x2, n_x2;
    logic [30:0]                         r_t, n_t;
    logic signed [cfis_pkg::PROD_BITS-1:0] r_prod, n_prod;

    logic [cfis_pkg::CNT_BITS-1:0] w_ticks;
    logic [cfis_pkg::CNT_BITS:0]   w_rem2;
    logic [14:0]                   w_gc;
    logic [29:0]                   w_ma;
    logic [30:0]                   w_mb;
    logic [60:0]                   w_mprod;
    logic [31:0]                   w_round;
    logic                          post_go;
    logic [cfis_pkg::GAIN_BITS-1:0] post_g;
    logic signed [cfis_pkg::PROD_BITS-1:0] w_sprod;

    assign w_ticks = (i_ctl.ticks == '0) ? 16'd1 : i_ctl.ticks;
    assign w_rem2  = {r_rem[cfis_pkg::CNT_BITS-1:0], 1'b0};
    assign w_gc    = (r_gain > {1'b0, cfis_pkg::GAIN_EP_MAX}) ? cfis_pkg::GAIN_EP_MAX
                                                           : r_gain[14:0];
    assign w_ma    = (r_step == 4'd0 || r_step == 4'd5) ? {15'd0, w_gc} : r_x2;
    assign w_mb    = (r_step == 4'd0) ? {16'd0, w_gc} : r_t;
    assign w_mprod = 61'(w_ma) * 61'(w_mb);
    assign w_round = 32'(w_mprod[45:15]) + 32'd16384;
    assign w_sprod = cfis_pkg::PROD_BITS'(i_sample) * $signed({1'b0, r_mix_gain});

    always_comb begin
        n_state    = r_state;
        n_done     = r_done;
        n_count    = r_count;
        n_gain     = r_gain;
        n_mix_gain = r_mix_gain;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_step     = r_step;
        n_x2       = r_x2;
        n_t        = r_t;
        n_prod     = r_prod;
        post_go    = 1'b0;
        post_g     = r_gain;
        unique case (r_state)
            L_IDLE: begin
                if (i_ctl.start) begin
                    n_done  = 1'b0;
                    post_go = 1'b1;
                    if (i_ctl.enabled) begin
                        if (r_count == '0) post_g = '0;
                        if (i_ctl.active && r_count < w_ticks) begin
                            n_count = r_count + 16'd1;
                            if (r_count != '0) begin
                                post_go = 1'b0;
                                n_rem   = {1'b0, r_count};
                                n_quo   = '0;
                                n_step  = '0;
                                n_state = L_DIV;
                            end
                        end else if (!i_ctl.active && r_count != '0) begin
                            n_count = r_count - 16'd1;
                            if (r_count >= w_ticks) begin
                                post_g = cfis_pkg::GAIN_ONE;
                            end else begin
                                post_go = 1'b0;
                                n_rem   = {1'b0, r_count};
                                n_quo   = '0;
                                n_step  = '0;
                                n_state = L_DIV;
                            end
                        end
                    end
                end
            end
            L_DIV: begin
                // One quotient bit per cycle; the count being divided is below ticks here.
                if (w_rem2 >= {1'b0, w_ticks}) begin
                    n_rem = w_rem2 - {1'b0, w_ticks};
                    n_quo = {r_quo[13:0], 1'b1};
                end else begin
                    n_rem = w_rem2;
                    n_quo = {r_quo[13:0], 1'b0};
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd14) begin
                    post_go = 1'b1;
                    post_g  = {1'b0, n_quo};
                end
            end
            L_POLY: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd0) begin
                    n_x2 = w_mprod[29:0];
                    n_t  = cfis_pkg::SIN_E;
                end else if (r_step != 4'd5) begin
                    n_t = cfis_pkg::poly_coef(r_step[2:0]) - w_mprod[60:30];
                end else begin
                    n_mix_gain = (w_round[31:15] > {1'b0, cfis_pkg::GAIN_ONE})
                                 ? cfis_pkg::GAIN_ONE : w_round[30:15];
                    n_state    = L_MUL;
                end
            end
            L_MUL: begin
                n_prod  = (i_ctl.enabled && r_mix_gain != '0) ? w_sprod : '0;
                n_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
        if (post_go) begin
            n_gain = post_g;
            if (i_ctl.shape && post_g != '0) begin
                n_step  = '0;
                n_state = L_POLY;
            end else begin
                n_mix_gain = post_g;
                n_state    = L_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
            r_gain  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
            r_gain  <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mix_gain <= n_mix_gain;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_step     <= n_step;
        r_x2       <= n_x2;
        r_t        <= n_t;
        r_prod     <= n_prod;
    end

    assign o_stat.done    = r_done;
    assign o_stat.product = r_prod;

endmodule

[sv/cfis_merge.sv]
// ----------------------------------------------------------------------------
// cfis_merge
// Sums the lane products one lane per cycle, then rounds and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfis_merge (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [cfis_pkg::PROD_BITS-1:0]   i_products [cfis_pkg::MAX_INPUTS],
    output logic                                    o_done,
    output logic signed [cfis_pkg::SAMPLE_BITS-1:0] o_mixed,
    output logic                                    o_clipped
);

    localparam int RES_BITS = cfis_pkg::SUM_BITS - 15;
    localparam logic signed [RES_BITS-1:0] HI =
        RES_BITS'((64'sd1 <<< (cfis_pkg::SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_BITS-1:0] LO = -HI - RES_BITS'(1);

    logic signed [cfis_pkg::SUM_BITS-1:0] r_sum;
    logic [cfis_pkg::LANE_BITS-1:0]       r_idx;
    logic                                 r_busy, r_done;

    logic signed [cfis_pkg::SUM_BITS-1:0] w_rnd;
    logic signed [RES_BITS-1:0]           w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == cfis_pkg::LANE_BITS'(cfis_pkg::MAX_INPUTS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= '0;
        end else if (r_busy) begin
            r_sum <= r_sum + cfis_pkg::SUM_BITS'(i_products[r_idx]);
        end
    end

    // Round half up, then shift down to sample scale.
    assign w_rnd = r_sum + cfis_pkg::SUM_BITS'(16384);
    assign w_res = RES_BITS'(w_rnd >>> 15);

    always_comb begin
        o_clipped = 1'b0;
        o_mixed   = cfis_pkg::SAMPLE_BITS'(w_res);
        if (w_res > HI) begin
            o_mixed   = cfis_pkg::SAMPLE_BITS'(HI);
            o_clipped = 1'b1;
        end else if (w_res < LO) begin
            o_mixed   = cfis_pkg::SAMPLE_BITS'(LO);
            o_clipped = 1'b1;
        end
    end

    assign o_done = r_done;

endmodule

[sv/crossfading_input_selector_unit.sv]
// ----------------------------------------------------------------------------
// crossfading_input_selector_unit
// Crossfading selector: eight lanes fade their gains, a merge stage mixes.
// ----------------------------------------------------------------------------
//   Channel  | Handshake          | Word
//   input    | i_valid / o_ready  | i_action, i_chosen_input, i_sample_0..7
//   output   | o_valid / i_ready  | o_mixed_sample, o_clipped
//   config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A choice word leaves the input ready and gives no result.
// A frame holds the input closed through the lane start, the gain division of
// 15 quotient bits if needed and 6 sine polynomial steps if shaped, per lane in
// parallel, the product, the handoff, the merge start and the lane-by-lane
// accumulation of all eight lanes, the handoff and the output load.
// Reset is synchronous and active low; no clearing pass is needed.
// A held output word stalls only the next frame's final load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crossfading_input_selector_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_action,
    input  logic signed [7:0]                       i_chosen_input,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_3,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_4,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_5,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_6,
    input  logic signed [cfis_pkg::SAMPLE_BITS-1:0] i_sample_7,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [cfis_pkg::SAMPLE_BITS-1:0] o_mixed_sample,
    output logic                                    o_clipped,
    input  logic                                    i_cfg_we,
    input  logic [1:0]                              i_cfg_index,
    input  logic [15:0]                             i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LANES = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    logic [3:0]  r_input_count;
    logic [15:0] r_fade_ticks;
    logic        r_fade_shape;
    logic [cfis_pkg::MAX_INPUTS-1:0] r_active, n_active;
    logic [3:0]  r_cur, r_prior;
    logic        r_lstart, r_mstart, r_silent;
    logic        r_out_valid, r_clip;
    logic signed [cfis_pkg::SAMPLE_BITS-1:0] r_mixed;
    logic signed [cfis_pkg::SAMPLE_BITS-1:0] r_samples [cfis_pkg::MAX_INPUTS];

    logic signed [cfis_pkg::SAMPLE_BITS-1:0] w_samples [cfis_pkg::MAX_INPUTS];
    cfis_pkg::t_lane_ctl  w_ctl  [cfis_pkg::MAX_INPUTS];
    cfis_pkg::t_lane_stat w_stat [cfis_pkg::MAX_INPUTS];
    logic signed [cfis_pkg::PROD_BITS-1:0] w_products [cfis_pkg::MAX_INPUTS];
    logic [cfis_pkg::MAX_INPUTS-1:0] w_done;
    logic [3:0]  w_n, w_choice;
    logic        w_accept, w_mdone, w_mclip, w_lanes_done, w_load;
    logic signed [cfis_pkg::SAMPLE_BITS-1:0] w_mmixed;

    assign w_samples[0] = i_sample_0;
    assign w_samples[1] = i_sample_1;
    assign w_samples[2] = i_sample_2;
    assign w_samples[3] = i_sample_3;
    assign w_samples[4] = i_sample_4;
    assign w_samples[5] = i_sample_5;
    assign w_samples[6] = i_sample_6;
    assign w_samples[7] = i_sample_7;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Done flags drop in the cycle after the start pulse.
    assign w_lanes_done = (r_state == S_LANES) && !r_lstart && (&w_done);
    assign w_load       = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Count of lanes in use, held to 1..8.
    always_comb begin
        if (r_input_count == 4'd0) begin
            w_n = 4'd1;
        end else if (r_input_count > 4'(cfis_pkg::MAX_INPUTS)) begin
            w_n = 4'(cfis_pkg::MAX_INPUTS);
        end else begin
            w_n = r_input_count;
        end
    end

    always_comb begin
        if (i_chosen_input[7]) begin
            w_choice = 4'd0;
        end else if ({1'b0, i_chosen_input[6:0]} > {4'd0, w_n}) begin
            w_choice = w_n;
        end else begin
            w_choice = i_chosen_input[3:0];
        end
    end

    always_comb begin
        n_active = r_active;
        if (w_choice != 4'd0) n_active[3'(w_choice - 4'd1)] = 1'b1;
        if (r_cur != 4'd0) n_active[3'(r_cur - 4'd1)] = 1'b0;
    end

    for (genvar g = 0; g < cfis_pkg::MAX_INPUTS; g++) begin : g_lane
        assign w_ctl[g].start   = r_lstart;
        assign w_ctl[g].enabled = (4'(g) < w_n);
        assign w_ctl[g].active  = r_active[g];
        assign w_ctl[g].ticks   = r_fade_ticks;
        assign w_ctl[g].shape   = r_fade_shape;
        assign w_done[g]        = w_stat[g].done;
        assign w_products[g]    = w_stat[g].product;

        cfis_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl[g]),
            .i_sample (r_samples[g]),
            .o_stat   (w_stat[g])
        );
    end

    cfis_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mstart),
        .i_products (w_products),
        .o_done     (w_mdone),
        .o_mixed    (w_mmixed),
        .o_clipped  (w_mclip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count <= 4'd1;
            r_fade_ticks  <= 16'd48;
            r_fade_shape  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cfis_pkg::REG_INPUT_COUNT: r_input_count <= i_cfg_data[3:0];
                cfis_pkg::REG_FADE_TICKS:  r_fade_ticks  <= i_cfg_data;
                cfis_pkg::REG_FADE_SHAPE:  r_fade_shape  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_cur       <= '0;
            r_prior     <= '0;
            r_lstart    <= 1'b0;
            r_mstart    <= 1'b0;
            r_silent    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lstart    <= (r_state == S_IDLE) && w_accept && !i_action;
            r_mstart    <= w_lanes_done;
            r_out_valid <= w_load || (r_out_valid && !i_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_action) begin
                        if (w_choice != r_cur) begin
                            r_active <= n_active;
                            r_prior  <= r_cur;
                            r_cur    <= w_choice;
                        end
                    end else if (w_accept) begin
                        r_silent <= (r_cur == 4'd0) && (r_prior == 4'd0);
                        r_state  <= S_LANES;
                    end
                end
                S_LANES: begin
                    if (w_lanes_done) r_state <= S_MERGE;
                end
                S_MERGE: begin
                    if (!r_mstart && w_mdone) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_action) begin
            r_samples <= w_samples;
        end
        if (w_load) begin
            r_mixed <= r_silent ? '0 : w_mmixed;
            r_clip  <= r_silent ? 1'b0 : w_mclip;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mixed_sample = r_mixed;
    assign o_clipped      = r_clip;

endmodule

[sv/cfis_checker.sv]
// ----------------------------------------------------------------------------
// cfis_checker
// Port-level checks of the crossfading input selector, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crossfading_input_selector_unit_assert.svh"

module cfis_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_valid,
    input logic                                    o_ready,
    input logic                                    i_action,
    input logic                                    o_valid,
    input logic                                    i_ready,
    input logic signed [cfis_pkg::SAMPLE_BITS-1:0] o_mixed_sample,
    input logic                                    o_clipped
);

    // A held word stays offered.
    `CFIS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "output word dropped")

    // A clipped word sits at one of the two rails.
    `CFIS_ASSERT(a_clip_rail, i_clk, i_rst_n, o_valid && o_clipped |-> (o_mixed_sample == 24'sh7fffff || o_mixed_sample == -24'sh800000), "clipped word off the rails")

    // A choice word never blocks the next word.
    `CFIS_ASSERT(a_choice_fast, i_clk, i_rst_n, i_valid && o_ready && i_action |=> o_ready, "choice word stalled input")

    // A frame keeps the input closed while the lanes work.
    `CFIS_ASSERT(a_frame_busy, i_clk, i_rst_n, i_valid && o_ready && !i_action |=> !o_ready, "frame did not start")

    // Reset empties the output.
    `CFIS_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind crossfading_input_selector_unit cfis_checker u_cfis_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the crossfading input selector: directed and random
// choice/frame words, predicted mix values compared with every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM   = 1930;
    localparam int WDOG_LIMIT = 20000;
    localparam int SETTLE     = 60;
    localparam logic [1:0] REG_CFG_UNUSED = 2'd3;

    typedef enum logic {ACT_FRAME = 1'b0, ACT_CHOICE = 1'b1} t_action;

    typedef struct {
        t_action              act;
        logic signed [7:0]    choice;
        logic signed [23:0]   smp [cfis_pkg::MAX_INPUTS];
        logic                 known;
        logic signed [23:0]   exp_mix;
        logic                 exp_clip;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_action = 1'b0;
    logic signed [7:0] i_chosen_input = '0;
    logic signed [23:0] i_smp [cfis_pkg::MAX_INPUTS];
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [23:0] o_mixed_sample;
    logic o_clipped;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    initial begin
        for (int k = 0; k < cfis_pkg::MAX_INPUTS; k++) i_smp[k] = '0;
    end

    crossfading_input_selector_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_chosen_input(i_chosen_input),
        .i_sample_0(i_smp[0]), .i_sample_1(i_smp[1]), .i_sample_2(i_smp[2]),
        .i_sample_3(i_smp[3]), .i_sample_4(i_smp[4]), .i_sample_5(i_smp[5]),
        .i_sample_6(i_smp[6]), .i_sample_7(i_smp[7]),
        .o_valid(o_valid), .i_ready(i_ready), .o_mixed_sample(o_mixed_sample),
        .o_clipped(o_clipped), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state.
    logic        lane_on   [cfis_pkg::MAX_INPUTS];
    logic [15:0] fade_cnt  [cfis_pkg::MAX_INPUTS];
    logic [16:0] gain_q15  [cfis_pkg::MAX_INPUTS];
    logic [3:0]  cur_sel, prev_sel;
    logic [3:0]  cfg_count;
    logic [15:0] cfg_ticks;
    logic        cfg_shape;

    logic signed [23:0] mix_q [$];
    logic               clip_q [$];
    int  n_fail = 0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;

    function automatic logic [16:0] ratio_q15(input logic [15:0] cnt, input logic [16:0] tk);
        logic [47:0] g;
        g = ({32'd0, cnt} * 48'd32768) / tk;
        if (g > 48'd32768) g = 48'd32768;
        return g[16:0];
    endfunction

    function automatic logic [16:0] sine_q15(input logic [16:0] g_in);
        logic [63:0] x, x2, t, s, g;
        g = g_in;
        if (g > 64'd32735) g = 64'd32735;
        x  = g << 15;
        x2 = (x * x) >> 30;
        t  = 64'd172271;
        t  = 64'd5026995 - ((x2 * t) >> 30);
        t  = 64'd85569306 - ((x2 * t) >> 30);
        t  = 64'd693598668 - ((x2 * t) >> 30);
        t  = 64'd1686629713 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32768) s = 64'd32768;
        return s[16:0];
    endfunction

    task automatic mixer_reset();
        for (int k = 0; k < cfis_pkg::MAX_INPUTS; k++) begin
            lane_on[k] = 1'b0; fade_cnt[k] = '0; gain_q15[k] = '0;
        end
        cur_sel = '0; prev_sel = '0;
        cfg_count = 4'd1; cfg_ticks = 16'd48; cfg_shape = 1'b0;
    endtask

    // Applies one accepted word to the model; frames push one expected word.
    task automatic mixer_step(input t_word w);
        int n;
        logic [16:0] tk, g;
        logic signed [63:0] sum, res;
        int f;
        logic [3:0] c;
        n  = (cfg_count < 1) ? 1 : (cfg_count > cfis_pkg::MAX_INPUTS ?
                                    cfis_pkg::MAX_INPUTS : cfg_count);
        tk = (cfg_ticks == 0) ? 17'd1 : {1'b0, cfg_ticks};
        if (w.act == ACT_CHOICE) begin
            f = w.choice;
            if (f < 0) f = 0;
            if (f > n) f = n;
            c = f[3:0];
            if (c != cur_sel) begin
                if (c != 0) lane_on[c-1] = 1'b1;
                if (cur_sel != 0) lane_on[cur_sel-1] = 1'b0;
                prev_sel = cur_sel;
                cur_sel  = c;
            end
            return;
        end
        for (int k = 0; k < n; k++) begin
            if (fade_cnt[k] == 0) gain_q15[k] = '0;
            if (lane_on[k] && fade_cnt[k] < tk) begin
                if (fade_cnt[k] != 0) gain_q15[k] = ratio_q15(fade_cnt[k], tk);
                fade_cnt[k] = fade_cnt[k] + 16'd1;
            end else if (!lane_on[k] && fade_cnt[k] > 0) begin
                gain_q15[k] = ratio_q15(fade_cnt[k], tk);
                fade_cnt[k] = fade_cnt[k] - 16'd1;
            end
        end
        if (cur_sel == 0 && prev_sel == 0) begin
            mix_q.push_back('0); clip_q.push_back(1'b0);
            return;
        end
        sum = 0;
        for (int k = 0; k < n; k++) begin
            g = gain_q15[k];
            if (g == 0) continue;
            if (cfg_shape) g = sine_q15(g);
            sum += 64'(w.smp[k]) * $signed({47'd0, g});
        end
        res = (sum + 64'sd16384) >>> 15;
        if (res > 64'sd8388607) begin
            mix_q.push_back(24'h7FFFFF); clip_q.push_back(1'b1);
        end else if (res < -64'sd8388608) begin
            mix_q.push_back(24'h800000); clip_q.push_back(1'b1);
        end else begin
            mix_q.push_back(res[23:0]); clip_q.push_back(1'b0);
        end
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            cfis_pkg::REG_INPUT_COUNT: cfg_count = val[3:0];
            cfis_pkg::REG_FADE_TICKS:  cfg_ticks = val;
            cfis_pkg::REG_FADE_SHAPE:  cfg_shape = val[0];
            default: ;
        endcase
    endtask

    // Lets outstanding words drain, then settles for a trailing choice.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (mix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_word(input t_word w);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= w.act;
        i_chosen_input <= w.choice;
        for (int k = 0; k < cfis_pkg::MAX_INPUTS; k++) i_smp[k] <= w.smp[k];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        mixer_step(w);
        if (w.known && w.act == ACT_FRAME) begin
            mix_q[$]  = w.exp_mix;
            clip_q[$] = w.exp_clip;
        end
    endtask

    function automatic t_word rand_word(input int choice_pct);
        t_word w;
        int r;
        w.act = ($urandom_range(0, 99) < choice_pct) ? ACT_CHOICE : ACT_FRAME;
        r = $urandom_range(0, 9);
        w.choice = (r == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
        for (int k = 0; k < cfis_pkg::MAX_INPUTS; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0) w.smp[k] = 24'h7FFFFF;
            else if (r == 1) w.smp[k] = 24'h800000;
            else w.smp[k] = 24'($urandom);
        end
        w.known = 1'b0; w.exp_mix = '0; w.exp_clip = 1'b0;
        return w;
    endfunction

    function automatic t_word mk(input t_action a, input int ch, input int s);
        t_word w;
        w.act = a; w.choice = 8'(ch);
        for (int k = 0; k < cfis_pkg::MAX_INPUTS; k++) w.smp[k] = 24'(s);
        w.known = 1'b0; w.exp_mix = '0; w.exp_clip = 1'b0;
        return w;
    endfunction

    // Frame row with its expected word typed in.
    function automatic t_word mkx(input int s, input int e_mix, input logic e_clip);
        t_word w;
        w = mk(ACT_FRAME, 0, s);
        w.known = 1'b1; w.exp_mix = 24'(e_mix); w.exp_clip = e_clip;
        return w;
    endfunction

    // Output checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (mix_q.size() == 0) begin
                $display("%0t: unexpected word mixed=%0d clipped=%0b", $time,
                    o_mixed_sample, o_clipped);
                n_fail++;
            end else begin
                if (o_mixed_sample !== mix_q[0] || o_clipped !== clip_q[0]) begin
                    $display("%0t: mismatch expected mixed=%0d clipped=%0b actual mixed=%0d clipped=%0b",
                        $time, mix_q[0], clip_q[0], o_mixed_sample, o_clipped);
                    n_fail++;
                end
                void'(mix_q.pop_front());
                void'(clip_q.pop_front());
            end
        end
    end

    // Receiver: random stalls plus one long hold-off.
    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            hold = ($urandom_range(0, 14) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 1);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold == 0) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("FAIL crossfading_input_selector_unit");
            $finish;
        end
    end

    initial begin
        t_word dir [$];
        t_word w;
        mixer_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Idle start: frames give zero before any choice.
        dir.push_back(mkx(8388607, 0, 1'b0));
        dir.push_back(mkx(-8388608, 0, 1'b0));
        foreach (dir[k]) begin
            send_word(dir[k]);
        end
        wait_drained();
        dir.delete();

        // Extremes: eight lanes, shortest fade, full-scale samples.
        cfg_write(cfis_pkg::REG_INPUT_COUNT, 16'd8);
        cfg_write(cfis_pkg::REG_FADE_TICKS, 16'd0);
        dir.push_back(mk(ACT_CHOICE, 127, 0));        // clamps to 8
        dir.push_back(mkx(8388607, 0, 1'b0));
        dir.push_back(mkx(8388607, 0, 1'b0));
        dir.push_back(mk(ACT_CHOICE, -128, 0));       // clamps to silence
        dir.push_back(mkx(-8388608, -8388608, 1'b0));
        dir.push_back(mk(ACT_CHOICE, 3, 0));
        dir.push_back(mk(ACT_CHOICE, 3, 0));          // repeated choice ignored
        dir.push_back(mk(ACT_FRAME, 0, -8388608));
        dir.push_back(mk(ACT_FRAME, 0, -8388608));
        foreach (dir[k]) send_word(dir[k]);
        wait_drained();
        dir.delete();

        // Equal-power fade, then lowered ticks with counters above them.
        cfg_write(cfis_pkg::REG_FADE_SHAPE, 16'd1);
        cfg_write(cfis_pkg::REG_FADE_TICKS, 16'd6);
        dir.push_back(mk(ACT_CHOICE, 1, 0));
        for (int k = 0; k < 5; k++) dir.push_back(mk(ACT_FRAME, 0, 4000000 - k * 1500000));
        foreach (dir[k]) send_word(dir[k]);
        wait_drained();
        dir.delete();
        cfg_write(cfis_pkg::REG_FADE_TICKS, 16'd2);
        cfg_write(cfis_pkg::REG_INPUT_COUNT, 16'd0);  // acts as one lane
        dir.push_back(mk(ACT_FRAME, 0, 1234567));
        dir.push_back(mk(ACT_CHOICE, 0, 0));
        dir.push_back(mk(ACT_FRAME, 0, -7654321));
        dir.push_back(mk(ACT_FRAME, 0, 8388607));
        foreach (dir[k]) send_word(dir[k]);
        wait_drained();
        dir.delete();
        cfg_write(cfis_pkg::REG_INPUT_COUNT, 16'd15); // acts as eight
        cfg_write(cfis_pkg::REG_FADE_TICKS, 16'd65535);
        cfg_write(REG_CFG_UNUSED, 16'hFFFF);
        send_word(mk(ACT_CHOICE, 2, 0));
        send_word(mk(ACT_FRAME, 0, 8388607));
        wait_drained();

        // Random phases with varied settings; the receiver stalls long once.
        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(cfis_pkg::REG_INPUT_COUNT, 16'($urandom_range(0, 15)));
            cfg_write(cfis_pkg::REG_FADE_TICKS,
                      (ph == 7) ? 16'd1 : 16'($urandom_range(1, 12)));
            cfg_write(cfis_pkg::REG_FADE_SHAPE, 16'(ph & 1));
            if (ph == 2) long_hold = 1'b1;
            for (int k = 0; k < N_RANDOM / 8; k++) begin
                w = rand_word(12);
                send_word(w);
            end
            wait_drained();
        end
        if (n_fail == 0) begin
            $display("PASS crossfading_input_selector_unit");
        end else begin
            $display("FAIL crossfading_input_selector_unit");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/cfis_pkg.sv
sv/cfis_lane.sv
sv/cfis_merge.sv
sv/crossfading_input_selector_unit.sv
sv/cfis_checker.sv
dv/tb_top.sv
